// ----- hw/rtl/ffra_pkg.sv -----
package ffra_pkg;

    // Default table depth
    localparam int unsigned MAX_RANGES_DEF = 16;

    // Field widths
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ENTRY_W  = 2 * DATA_W;
    localparam int unsigned STATUS_W = 2;

    // Operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_END       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_SHIFT,
        S_COMMIT,
        S_FINISH
    } ffra_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic check;
        logic shift;
        logic commit;
        logic finish;
    } ffra_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic full_alloc;
        logic scan_done;
        logic skip;
        logic shift_done;
        logic out_free;
    } ffra_stat_t;

endpackage

// ----- hw/rtl/ffra_ram.sv -----
module ffra_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/ffra_ctrl.sv -----
module ffra_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output ffra_pkg::ffra_cmd_t cmd,
    input  ffra_pkg::ffra_stat_t st
);

    import ffra_pkg::*;

    ffra_state_t state_reg;
    ffra_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                priority if (st.full_alloc)
                begin
                    state_next = S_FINISH;
                end
                else if (st.scan_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                priority if (st.skip)
                begin
                    state_next = S_FINISH;
                end
                else if (st.shift_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_SCAN:   cmd.scan   = 1'b1;
            S_CHECK:  cmd.check  = 1'b1;
            S_SHIFT:  cmd.shift  = 1'b1;
            S_COMMIT: cmd.commit = 1'b1;
            S_FINISH: cmd.finish = 1'b1;
            default:  cmd        = '0;
        endcase
    end

endmodule

// ----- hw/rtl/ffra_dp.sv -----
module ffra_dp #(
    parameter int unsigned MAX_RANGES = ffra_pkg::MAX_RANGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ffra_pkg::ffra_cmd_t           cmd,
    output ffra_pkg::ffra_stat_t          st,
    input  logic                          func,
    input  logic [ffra_pkg::DATA_W-1:0]   req_size,
    input  logic [ffra_pkg::DATA_W-1:0]   free_offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ffra_pkg::DATA_W-1:0]   alloc_offset,
    output logic [ffra_pkg::STATUS_W-1:0] status
);

    import ffra_pkg::*;

    localparam int unsigned CW = $clog2(MAX_RANGES + 1);
    localparam int unsigned AW = $clog2(MAX_RANGES);

    // Control registers
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          dv_reg, dv_next;
    logic          found_reg, found_next;
    logic          skip_reg, skip_next;
    logic          end_err_reg, end_err_next;
    logic          full_hit_reg, full_hit_next;
    logic          out_valid_reg, out_valid_next;

    // Payload registers
    logic                func_reg, func_next;
    logic [DATA_W-1:0]   size_reg, size_next;
    logic [DATA_W-1:0]   key_reg, key_next;
    logic [CW-1:0]       didx_reg, didx_next;
    logic [DATA_W:0]     prev_end_reg, prev_end_next;
    logic [DATA_W-1:0]   prev_start_reg, prev_start_next;
    logic [DATA_W:0]     place_reg, place_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic                dup_reg, dup_next;
    logic [DATA_W-1:0]   alloc_offset_reg, alloc_offset_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // Table memory
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    ffra_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RANGES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Entry under test and gap arithmetic
    logic [DATA_W-1:0] ent_start;
    logic [DATA_W-1:0] ent_len;
    logic [DATA_W:0]   ent_end;
    logic [DATA_W+1:0] gap_diff;
    logic              first_ent;
    logic              fit;
    logic [DATA_W:0]   cand;
    logic              cand_dup;

    assign ent_start = ram_rdata[ENTRY_W-1:DATA_W];
    assign ent_len   = ram_rdata[DATA_W-1:0];
    assign ent_end   = {1'b0, ent_start} + {1'b0, ent_len};
    assign gap_diff  = {2'b00, ent_start} - {1'b0, prev_end_reg};
    assign first_ent = (didx_reg == '0);
    assign fit       = first_ent ? (ent_start >= size_reg)
                                 : (!gap_diff[DATA_W+1] &&
                                    (gap_diff[DATA_W:0] >= {1'b0, size_reg}));
    assign cand      = first_ent ? '0 : prev_end_reg;
    assign cand_dup  = ({1'b0, ent_start} == cand) ||
                       (!first_ent && ({1'b0, prev_start_reg} == cand));

    // Final placement: the found gap, or after the last range when the scan ran off the end of the table
    logic [DATA_W:0]   place_fin;
    logic              dup_fin;
    logic [CW-1:0]     pos_fin;
    logic [DATA_W+1:0] end_sum;
    logic              end_err_fin;

    assign place_fin   = found_reg ? place_reg
                                   : ((count_reg == '0) ? '0 : prev_end_reg);
    assign dup_fin     = found_reg ? dup_reg
                                   : ((count_reg != '0) &&
                                      ({1'b0, prev_start_reg} == prev_end_reg));
    assign pos_fin     = found_reg ? pos_reg : count_reg;
    assign end_sum     = {1'b0, place_fin} + {2'b00, size_reg};
    assign end_err_fin = place_fin[DATA_W] ||
                         (end_sum > {2'b01, {DATA_W{1'b0}}});

    // Index helpers
    logic [CW-1:0] ptr_inc, ptr_dec, idx_inc, idx_dec, pos_inc;

    assign ptr_inc = ptr_reg + 1'b1;
    assign ptr_dec = ptr_reg - 1'b1;
    assign idx_inc = didx_reg + 1'b1;
    assign idx_dec = didx_reg - 1'b1;
    assign pos_inc = pos_reg + 1'b1;

    // Status to controller
    logic full;

    assign full          = (count_reg == CW'(MAX_RANGES));
    assign st.full_alloc = (func_reg == FUNC_ALLOC) && full;
    assign st.scan_done  = found_reg || ((ptr_reg == count_reg) && !dv_reg);
    assign st.skip       = skip_reg;
    assign st.shift_done = skip_reg ||
                           (!dv_reg && ((func_reg == FUNC_ALLOC) ? (ptr_reg == pos_reg)
                                                                 : (ptr_reg == count_reg)));
    assign st.out_free   = !out_valid_reg || out_ready;

    // Next-state logic of the datapath
    always_comb
    begin
        count_next        = count_reg;
        ptr_next          = ptr_reg;
        dv_next           = dv_reg;
        found_next        = found_reg;
        skip_next         = skip_reg;
        end_err_next      = end_err_reg;
        full_hit_next     = full_hit_reg;
        out_valid_next    = out_valid_reg;
        func_next         = func_reg;
        size_next         = size_reg;
        key_next          = key_reg;
        didx_next         = didx_reg;
        prev_end_next     = prev_end_reg;
        prev_start_next   = prev_start_reg;
        place_next        = place_reg;
        pos_next          = pos_reg;
        dup_next          = dup_reg;
        alloc_offset_next = alloc_offset_reg;
        status_next       = status_reg;
        ram_we            = 1'b0;
        ram_waddr         = '0;
        ram_wdata         = ram_rdata;
        ram_re            = 1'b0;
        ram_raddr         = '0;

        // Capture the transaction and note a full table before any commit
        if (cmd.load)
        begin
            func_next     = func;
            size_next     = req_size;
            key_next      = free_offset;
            ptr_next      = '0;
            dv_next       = 1'b0;
            found_next    = 1'b0;
            end_err_next  = 1'b0;
            skip_next     = 1'b0;
            full_hit_next = (func == FUNC_ALLOC) && full;
        end

        // Walk the table in offset order, one read per cycle
        if (cmd.scan)
        begin
            dv_next = 1'b0;
            if (!found_reg && (ptr_reg != count_reg))
            begin
                ram_re    = 1'b1;
                ram_raddr = ptr_reg[AW-1:0];
                ptr_next  = ptr_inc;
                dv_next   = 1'b1;
                didx_next = ptr_reg;
            end
            if (dv_reg && !found_reg)
            begin
                if (func_reg == FUNC_ALLOC)
                begin
                    if (fit)
                    begin
                        found_next = 1'b1;
                        place_next = cand;
                        pos_next   = didx_reg;
                        dup_next   = cand_dup;
                    end
                    else
                    begin
                        prev_end_next   = ent_end;
                        prev_start_next = ent_start;
                    end
                end
                else if (ent_start == key_reg)
                begin
                    found_next = 1'b1;
                    pos_next   = didx_reg;
                end
            end
        end

        // Settle placement, range check and shift start
        if (cmd.check)
        begin
            dv_next = 1'b0;
            if (func_reg == FUNC_ALLOC)
            begin
                place_next   = place_fin;
                pos_next     = pos_fin;
                dup_next     = dup_fin;
                end_err_next = end_err_fin;
                skip_next    = end_err_fin || dup_fin;
                ptr_next     = count_reg;
            end
            else
            begin
                skip_next = !found_reg;
                ptr_next  = pos_inc;
            end
        end

        // Move entries up (allocate) or down (free), one per cycle
        if (cmd.shift && !skip_reg)
        begin
            dv_next = 1'b0;
            if (func_reg == FUNC_ALLOC)
            begin
                if (ptr_reg != pos_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_dec[AW-1:0];
                    ptr_next  = ptr_dec;
                    dv_next   = 1'b1;
                    didx_next = ptr_dec;
                end
                if (dv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_inc[AW-1:0];
                end
            end
            else
            begin
                if (ptr_reg != count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg[AW-1:0];
                    ptr_next  = ptr_inc;
                    dv_next   = 1'b1;
                    didx_next = ptr_reg;
                end
                if (dv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_dec[AW-1:0];
                end
            end
        end

        // Store the new range or drop the freed one
        if (cmd.commit)
        begin
            if (func_reg == FUNC_ALLOC)
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[AW-1:0];
                ram_wdata  = {place_reg[DATA_W-1:0], size_reg};
                count_next = count_reg + 1'b1;
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end

        // Output register
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish && st.out_free)
        begin
            out_valid_next    = 1'b1;
            alloc_offset_next = '0;
            priority if (func_reg == FUNC_FREE)
            begin
                status_next = found_reg ? ST_OK : ST_NOT_FOUND;
            end
            else if (full_hit_reg)
            begin
                status_next = ST_FULL;
            end
            else if (end_err_reg)
            begin
                status_next = ST_END;
            end
            else
            begin
                status_next       = ST_OK;
                alloc_offset_next = place_reg[DATA_W-1:0];
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            dv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            skip_reg      <= 1'b0;
            end_err_reg   <= 1'b0;
            full_hit_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            dv_reg        <= dv_next;
            found_reg     <= found_next;
            skip_reg      <= skip_next;
            end_err_reg   <= end_err_next;
            full_hit_reg  <= full_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg         <= func_next;
        size_reg         <= size_next;
        key_reg          <= key_next;
        didx_reg         <= didx_next;
        prev_end_reg     <= prev_end_next;
        prev_start_reg   <= prev_start_next;
        place_reg        <= place_next;
        pos_reg          <= pos_next;
        dup_reg          <= dup_next;
        alloc_offset_reg <= alloc_offset_next;
        status_reg       <= status_next;
    end

    assign out_valid    = out_valid_reg;
    assign alloc_offset = alloc_offset_reg;
    assign status       = status_reg;

    // The table never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RANGES))
        else $error("range count beyond table depth");

    // A nonzero offset is only ever reported with a good status
    a_offset_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (alloc_offset_reg != '0)) |-> (status_reg == ST_OK))
        else $error("offset reported with error status");

    // A committed allocation grows the table by one entry
    a_commit_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (func_reg == FUNC_ALLOC)) |=>
            (count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("allocation commit did not grow table");

    // The table is written only while shifting or committing
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (cmd.shift || cmd.commit))
        else $error("table write outside shift or commit");

endmodule

// ----- hw/rtl/first_fit_range_allocator_top.sv -----
// First-fit range allocator. Keeps up to MAX_RANGES allocated ranges sorted by
// start offset in a single table memory. An allocate transaction (func 0)
// places req_size in the first gap, including the gap before the first range,
// that is at least as large, or else after the last range, and returns the
// offset; a free transaction (func 1) removes the range that starts at
// free_offset. Every transaction yields one result with a status: 0 ok,
// 1 table full, 2 range would pass the 32-bit end, 3 free offset not found.
// One transaction is processed at a time: the table is walked one entry per
// cycle through the memory's single read port up to the chosen slot, then the
// entries past it are moved one per cycle to open or close the slot. The
// result sits in an output register, so the next transaction can be accepted
// in the cycle after the result is registered, while the result waits to be
// taken.
module first_fit_range_allocator_top #(
    parameter int unsigned MAX_RANGES = ffra_pkg::MAX_RANGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [ffra_pkg::DATA_W-1:0]   req_size,
    input  logic [ffra_pkg::DATA_W-1:0]   free_offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ffra_pkg::DATA_W-1:0]   alloc_offset,
    output logic [ffra_pkg::STATUS_W-1:0] status
);

    import ffra_pkg::*;

    ffra_cmd_t  cmd;
    ffra_stat_t st;

    // Sequencer
    ffra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .st       (st)
    );

    // Table, scan and output datapath
    ffra_dp #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .func         (func),
        .req_size     (req_size),
        .free_offset  (free_offset),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .alloc_offset (alloc_offset),
        .status       (status)
    );

endmodule
